>>> src/nfcfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcfb_pkg
// Shared constants and types of the information frame builder: the fixed
// frame bytes, the length limits and the queue entry passed from the front
// part to the back part.
// ----------------------------------------------------------------------------
package nfcfb_pkg;

   // Fixed bytes of the host-to-controller information frame.
   localparam logic [7:0] HdrDataWrite = 8'h01;
   localparam logic [7:0] Preamble     = 8'h00;
   localparam logic [7:0] StartCode1   = 8'h00;
   localparam logic [7:0] StartCode2   = 8'hFF;
   localparam logic [7:0] DirHostOut   = 8'hD4;
   localparam logic [7:0] Postamble    = 8'h00;

   // Payload length limits.
   localparam logic [7:0] LenMin = 8'd1;
   localparam logic [7:0] LenMax = 8'd254;

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   // One classified payload byte, as the back part needs it.
   typedef struct packed {
      logic [7:0] data;       // payload byte itself
      logic [7:0] frame_len;  // LEN field of the frame head
      logic [7:0] data_csum;  // data checksum, valid when close is set
      logic       open;       // frame head goes before this byte
      logic       close;      // checksum and postamble go after this byte
   } entry_type;

endpackage

>>> src/nfc_command_frame_builder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_command_frame_builder_unit
// Builds host-to-controller information frames from a stream of payload bytes.
// ----------------------------------------------------------------------------
// Payload bytes are accepted one per cycle while the internal four-entry
// queue has room. The output register sends one frame byte per cycle while
// the receiver is ready: a middle payload byte yields one frame byte, the
// first byte of a frame eight (seven head bytes and the byte), the last byte
// three (byte, data checksum and postamble) and a single-byte frame ten.
// Sustained throughput is therefore set by the output register; back-to-back
// payload bytes inside a frame stream at one per cycle while it is not stalled.
module nfc_command_frame_builder_unit (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_payload_byte,
   input  wire  [7:0] req_payload_length,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_end_of_frame,
   output logic       rsp_last_of_run
);

   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_not_empty;
   nfcfb_pkg::entry_type push_entry;
   nfcfb_pkg::entry_type head_entry;

   // Front part: accept and classify.
   nfcfb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   // Queue between the two parts.
   nfcfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   // Back part: emit the frame bytes.
   nfcfb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_valid      (queue_not_empty),
      .entry            (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
`default_nettype wire

>>> src/nfcfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcfb_front
// Accepts payload bytes, keeps the byte count and the running sum of the open
// frame, and classifies each byte as opening and/or closing a frame.
// ----------------------------------------------------------------------------
module nfcfb_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_payload_byte,
   input  wire  [7:0]            req_payload_length,
   input  wire                   queue_full,
   output logic                  push,
   output nfcfb_pkg::entry_type  push_entry
);

   logic [7:0] bytes_seen_ff;
   logic [7:0] bytes_seen_in;
   logic [7:0] running_sum_ff;
   logic [7:0] running_sum_in;

   logic [7:0] len;
   logic       first;
   logic [7:0] sum_base;
   logic [7:0] sum_new;
   logic [8:0] seen_new;
   logic       close;

   // Clamp the length and classify the byte against the open frame.
   always_comb begin
      if (req_payload_length < nfcfb_pkg::LenMin) begin
         len = nfcfb_pkg::LenMin;
      end else if (req_payload_length > nfcfb_pkg::LenMax) begin
         len = nfcfb_pkg::LenMax;
      end else begin
         len = req_payload_length;
      end
      first    = (bytes_seen_ff == 8'd0);
      sum_base = first ? nfcfb_pkg::DirHostOut : running_sum_ff;
      sum_new  = sum_base + req_payload_byte;
      seen_new = {1'b0, bytes_seen_ff} + 9'd1;
      close    = (seen_new >= {1'b0, len});
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_entry.data      = req_payload_byte;
      push_entry.frame_len = len + 8'd1;
      push_entry.data_csum = 8'd0 - sum_new;
      push_entry.open      = first;
      push_entry.close     = close;
   end

   // Frame state after this transaction; a closing byte returns to no frame.
   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      running_sum_in = running_sum_ff;
      if (push) begin
         if (close) begin
            bytes_seen_in  = 8'd0;
            running_sum_in = 8'd0;
         end else begin
            bytes_seen_in  = seen_new[7:0];
            running_sum_in = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= 8'd0;
         running_sum_ff <= 8'd0;
      end else begin
         bytes_seen_ff  <= bytes_seen_in;
         running_sum_ff <= running_sum_in;
      end
   end

`ifndef SYNTH
   // With no frame open the sum must also be cleared.
   a_idle_sum_clear: assert property (@(posedge clock) disable iff (reset)
      (bytes_seen_ff == 8'd0) |-> (running_sum_ff == 8'd0))
      else $error("running sum not cleared while no frame is open");
`endif

endmodule
`default_nettype wire

>>> src/nfcfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcfb_queue
// Short first-in first-out queue of classified payload bytes between the
// front and back parts.
// ----------------------------------------------------------------------------
module nfcfb_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  nfcfb_pkg::entry_type  push_entry,
   input  wire                   pop,
   output logic                  full,
   output logic                  not_empty,
   output nfcfb_pkg::entry_type  head_entry
);

   localparam int Aw = nfcfb_pkg::QueueAw;

   nfcfb_pkg::entry_type mem [nfcfb_pkg::QueueDepth];

   logic [Aw-1:0] wr_ptr_ff;
   logic [Aw-1:0] rd_ptr_ff;
   logic [Aw:0]   count_ff;
   logic [Aw:0]   count_in;

   assign full       = (count_ff == (Aw+1)'(nfcfb_pkg::QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   // Occupancy follows pushes and pops of the same cycle.
   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (Aw+1)'(1);
         2'b01:   count_in = count_ff - (Aw+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Aw'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Aw'(1);
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

>>> src/nfcfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcfb_back
// Steps through the frame bytes due for the head queue entry and holds each
// one in the output register until the link side takes it.
// ----------------------------------------------------------------------------
module nfcfb_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   entry_valid,
   input  nfcfb_pkg::entry_type  entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_end_of_frame,
   output logic                  rsp_last_of_run
);

   typedef enum logic [3:0] {
      STEP_HDR,
      STEP_PRE,
      STEP_SC1,
      STEP_SC2,
      STEP_LEN,
      STEP_LCS,
      STEP_DIR,
      STEP_DATA,
      STEP_DCS,
      STEP_POST
   } step_type;

   step_type   step_ff;
   step_type   cur_step;
   step_type   next_step;
   logic       final_step;
   logic       load;
   logic [7:0] byte_sel;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_frame_byte_ff;
   logic       rsp_end_of_frame_ff;
   logic       rsp_last_of_run_ff;

   // A byte that opens no frame starts directly at the payload step.
   always_comb begin
      if (step_ff == STEP_HDR && !entry.open) begin
         cur_step = STEP_DATA;
      end else begin
         cur_step = step_ff;
      end
   end

   // Byte for the current step and the step after it.
   always_comb begin
      byte_sel   = nfcfb_pkg::Postamble;
      next_step  = STEP_HDR;
      final_step = 1'b0;
      unique case (cur_step)
         STEP_HDR: begin
            byte_sel  = nfcfb_pkg::HdrDataWrite;
            next_step = STEP_PRE;
         end
         STEP_PRE: begin
            byte_sel  = nfcfb_pkg::Preamble;
            next_step = STEP_SC1;
         end
         STEP_SC1: begin
            byte_sel  = nfcfb_pkg::StartCode1;
            next_step = STEP_SC2;
         end
         STEP_SC2: begin
            byte_sel  = nfcfb_pkg::StartCode2;
            next_step = STEP_LEN;
         end
         STEP_LEN: begin
            byte_sel  = entry.frame_len;
            next_step = STEP_LCS;
         end
         STEP_LCS: begin
            byte_sel  = 8'd0 - entry.frame_len;
            next_step = STEP_DIR;
         end
         STEP_DIR: begin
            byte_sel  = nfcfb_pkg::DirHostOut;
            next_step = STEP_DATA;
         end
         STEP_DATA: begin
            byte_sel   = entry.data;
            next_step  = STEP_DCS;
            final_step = !entry.close;
         end
         STEP_DCS: begin
            byte_sel  = entry.data_csum;
            next_step = STEP_POST;
         end
         STEP_POST: begin
            byte_sel   = nfcfb_pkg::Postamble;
            next_step  = STEP_HDR;
            final_step = 1'b1;
         end
         default: begin
            byte_sel   = nfcfb_pkg::Postamble;
            next_step  = STEP_HDR;
            final_step = 1'b1;
         end
      endcase
   end

   // Load the output register from a valid queue entry whenever it is empty or being emptied.
   assign load         = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign pop          = load && final_step;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   // Step state and the output register move together on each load.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff             <= STEP_HDR;
         rsp_valid_ff        <= 1'b0;
         rsp_frame_byte_ff   <= 8'd0;
         rsp_end_of_frame_ff <= 1'b0;
         rsp_last_of_run_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            step_ff             <= final_step ? STEP_HDR : next_step;
            rsp_frame_byte_ff   <= byte_sel;
            rsp_end_of_frame_ff <= (cur_step == STEP_POST);
            rsp_last_of_run_ff  <= final_step;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_frame_byte_ff;
   assign rsp_end_of_frame = rsp_end_of_frame_ff;
   assign rsp_last_of_run  = rsp_last_of_run_ff;

`ifndef SYNTH
   // The postamble is always the last byte caused by its payload byte.
   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_of_frame_ff) |-> rsp_last_of_run_ff)
      else $error("end of frame without last of run");
   // A queue entry is released only at the end of its step sequence; the step rewinds to the frame head.
   a_pop_resets_step: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == STEP_HDR))
      else $error("step counter not rewound after pop");
`endif

endmodule
`default_nettype wire

>>> verif/nfc_command_frame_builder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_command_frame_builder_checker
// Watches both channels of the frame builder, works out the frame bytes that
// every accepted payload byte must produce and compares each result with them.
// ----------------------------------------------------------------------------
module nfc_command_frame_builder_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire  [7:0] req_payload_byte,
   input  wire  [7:0] req_payload_length,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire  [7:0] rsp_frame_byte,
   input  wire        rsp_end_of_frame,
   input  wire        rsp_last_of_run,
   output int         fail_count,
   output int         pending_count
);

   // One frame byte as it should leave the block.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
      logic       last_of_run;
   } frame_out_type;

   // Frame bytes still owed by the block, oldest first.
   frame_out_type awaited_bytes[$];

   // Bytes caused by the payload byte being predicted.
   frame_out_type run_buf[10];
   int            run_len;

   // Shadow of the open frame: payload bytes taken and their running sum.
   logic [7:0] open_count;
   logic [7:0] open_sum;

   int            mismatch_total;
   frame_out_type got;
   frame_out_type want;

   initial begin
      mismatch_total = 0;
      open_count     = 8'd0;
      open_sum       = 8'd0;
   end

   function automatic void put_byte(input logic [7:0] value, input logic eof);
      run_buf[run_len] = '{frame_byte: value, end_of_frame: eof, last_of_run: 1'b0};
      run_len = run_len + 1;
   endfunction

   // Works out the frame bytes that one payload byte produces and updates
   // the shadow of the open frame.
   function automatic void predict_frame_bytes(input logic [7:0] data,
                                               input logic [7:0] len_in);
      logic [7:0] len;
      logic [7:0] frame_len;
      len     = len_in;
      run_len = 0;
      // Out-of-range lengths are clamped to the legal range.
      if (len < nfcfb_pkg::LenMin) begin
         len = nfcfb_pkg::LenMin;
      end
      if (len > nfcfb_pkg::LenMax) begin
         len = nfcfb_pkg::LenMax;
      end
      // The first byte of a frame is preceded by the frame head.
      if (open_count == 8'd0) begin
         frame_len = len + 8'd1;
         put_byte(nfcfb_pkg::HdrDataWrite, 1'b0);
         put_byte(nfcfb_pkg::Preamble, 1'b0);
         put_byte(nfcfb_pkg::StartCode1, 1'b0);
         put_byte(nfcfb_pkg::StartCode2, 1'b0);
         put_byte(frame_len, 1'b0);
         put_byte(8'd0 - frame_len, 1'b0);
         put_byte(nfcfb_pkg::DirHostOut, 1'b0);
         open_sum = nfcfb_pkg::DirHostOut;
      end
      put_byte(data, 1'b0);
      open_sum   = open_sum + data;
      open_count = open_count + 8'd1;
      // The length that comes with this byte decides whether the frame closes.
      if (open_count >= len) begin
         put_byte(8'd0 - open_sum, 1'b0);
         put_byte(nfcfb_pkg::Postamble, 1'b1);
         open_count = 8'd0;
         open_sum   = 8'd0;
      end
      run_buf[run_len - 1].last_of_run = 1'b1;
      for (int i = 0; i < run_len; i++) begin
         awaited_bytes.push_back(run_buf[i]);
      end
   endfunction

   // Prediction on accepted payload bytes, comparison on accepted results.
   always @(posedge clock) begin
      if (reset) begin
         awaited_bytes.delete();
         open_count = 8'd0;
         open_sum   = 8'd0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame_bytes(req_payload_byte, req_payload_length);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{frame_byte: rsp_frame_byte, end_of_frame: rsp_end_of_frame,
                    last_of_run: rsp_last_of_run};
            if (awaited_bytes.size() == 0) begin
               $error("unexpected result transaction: frame_byte %02h", got.frame_byte);
               mismatch_total = mismatch_total + 1;
            end else begin
               want = awaited_bytes.pop_front();
               if (got.frame_byte !== want.frame_byte) begin
                  $error("frame_byte mismatch: expected %02h, actual %02h",
                         want.frame_byte, got.frame_byte);
                  mismatch_total = mismatch_total + 1;
               end
               if (got.end_of_frame !== want.end_of_frame) begin
                  $error("end_of_frame mismatch: expected %0b, actual %0b",
                         want.end_of_frame, got.end_of_frame);
                  mismatch_total = mismatch_total + 1;
               end
               if (got.last_of_run !== want.last_of_run) begin
                  $error("last_of_run mismatch: expected %0b, actual %0b",
                         want.last_of_run, got.last_of_run);
                  mismatch_total = mismatch_total + 1;
               end
            end
         end
      end
      pending_count <= awaited_bytes.size();
      fail_count    <= mismatch_total;
   end

endmodule

>>> verif/tb_nfc_command_frame_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfc_command_frame_builder_unit
// Drives payload bytes into the frame builder and gives the verdict.
// ----------------------------------------------------------------------------
// A directed set of frames covers the length limits, out-of-range lengths and
// lengths that change inside a frame; a mix of well-formed frames and noise
// follows. The sender works in bursts, the receiver stalls in changing
// patterns, and the checker beside the block compares every frame byte.
module tb_nfc_command_frame_builder_unit;

   localparam int IdleLimit = 2000;
   localparam int HoldOff   = 20;

   typedef enum logic [1:0] {
      ReadyAlways,
      ReadyCoinFlip,
      ReadySparse
   } ready_mode_type;

   // One payload byte to send; a pause waits for the block to drain first.
   typedef struct {
      logic [7:0] data;
      logic [7:0] len;
      bit         pause;
   } payload_item_type;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic [7:0] req_payload_byte   = 8'd0;
   logic [7:0] req_payload_length = 8'd0;
   logic       rsp_ready          = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire  [7:0] rsp_frame_byte;
   wire        rsp_end_of_frame;
   wire        rsp_last_of_run;

   int             fail_count;
   int             pending_count;
   int             idle_cycles = 0;
   ready_mode_type ready_mode  = ReadyAlways;
   int             ready_left  = 0;

   payload_item_type payload_list[$];

   nfc_command_frame_builder_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   nfc_command_frame_builder_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_last_of_run    (rsp_last_of_run),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always #2 clock = ~clock;

   // The receiver switches between always ready, coin flips and long stalls.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         ready_left <= $urandom_range(20, 150);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         ReadyAlways: begin
            rsp_ready <= 1'b1;
         end
         ReadyCoinFlip: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // The run ends if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("tb_nfc_command_frame_builder_unit failed");
            $finish;
         end
      end
   end

   function automatic void add_item(input logic [7:0] data, input logic [7:0] len,
                                    input bit pause);
      payload_list.push_back('{data: data, len: len, pause: pause});
   endfunction

   // Builds the directed frames and the random mix.
   function automatic void build_payload_list();
      int random_items;
      int frame_len;
      int noise_len;
      bit pause;
      random_items = 0;
      // Single-byte frames with the extreme data values.
      add_item(8'h00, 8'd1, 1'b0);
      add_item(8'hFF, 8'd1, 1'b0);
      // A length of zero gives a single-byte frame.
      add_item(8'h5A, 8'd0, 1'b0);
      // A plain three-byte frame.
      add_item(8'h80, 8'd3, 1'b0);
      add_item(8'h7F, 8'd3, 1'b0);
      add_item(8'h01, 8'd3, 1'b0);
      // The length grows inside the frame.
      add_item(8'h11, 8'd2, 1'b0);
      add_item(8'h22, 8'd4, 1'b0);
      add_item(8'h33, 8'd4, 1'b0);
      add_item(8'h44, 8'd4, 1'b0);
      // The largest legal length, then a shrink that is already passed.
      add_item(8'hA5, 8'd254, 1'b0);
      add_item(8'hC3, 8'd1, 1'b0);
      // A length above the limit, then one that closes the frame.
      add_item(8'hF0, 8'd255, 1'b0);
      add_item(8'h0F, 8'd2, 1'b0);
      // Two-byte frames whose sums wrap.
      add_item(8'hFF, 8'd2, 1'b0);
      add_item(8'hFF, 8'd2, 1'b0);
      add_item(8'h80, 8'd2, 1'b0);
      add_item(8'h80, 8'd2, 1'b0);
      // Mostly well-formed frames of small size, with some noise between them.
      // The first group always waits for the block to drain.
      while (random_items < 232) begin
         pause = (random_items == 0) || ($urandom_range(0, 15) == 0);
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 7) == 0) begin
               frame_len = $urandom_range(9, 40);
            end else begin
               frame_len = $urandom_range(1, 8);
            end
            for (int i = 0; i < frame_len; i++) begin
               add_item(8'($urandom_range(0, 255)), 8'(frame_len), pause && (i == 0));
            end
            random_items = random_items + frame_len;
         end else begin
            noise_len = $urandom_range(1, 4);
            for (int i = 0; i < noise_len; i++) begin
               add_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        pause && (i == 0));
            end
            random_items = random_items + noise_len;
         end
      end
   endfunction

   // Stimulus and verdict.
   initial begin
      int  idx;
      int  burst_left;
      bit  drop_valid;
      build_payload_list();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 16);
      for (idx = 0; idx < payload_list.size(); idx++) begin
         // Hold off until every expected frame byte has come.
         if (payload_list[idx].pause) begin
            while (pending_count != 0) begin
               @(posedge clock);
            end
         end
         req_valid          <= 1'b1;
         req_payload_byte   <= payload_list[idx].data;
         req_payload_length <= payload_list[idx].len;
         do begin
            @(posedge clock);
         end while (!req_ready);
         burst_left = burst_left - 1;
         drop_valid = (idx == payload_list.size() - 1) || (burst_left <= 0);
         if (!drop_valid) begin
            drop_valid = payload_list[idx + 1].pause;
         end
         // Valid is lowered in the step of acceptance, so no item repeats.
         if (drop_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            if (burst_left <= 0) begin
               if ($urandom_range(0, 4) == 0) begin
                  burst_left = $urandom_range(40, 120);
               end else begin
                  burst_left = $urandom_range(1, 16);
               end
            end
         end
      end
      // Drain the block, then wait out the hold-off time for stray results.
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (HoldOff) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_nfc_command_frame_builder_unit passed");
      end else begin
         $display("tb_nfc_command_frame_builder_unit failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/nfcfb_pkg.sv
src/nfcfb_front.sv
src/nfcfb_queue.sv
src/nfcfb_back.sv
src/nfc_command_frame_builder_unit.sv
verif/nfc_command_frame_builder_checker.sv
verif/tb_nfc_command_frame_builder_unit.sv
